/* rtl/sdep_pkg.sv */
// Shared types, constants and helpers of the SSE data event parser.
`default_nettype none

package sdep_pkg;

	localparam int LINE_BITS  = 21;
	localparam int EVENT_BITS = 22;
	localparam int DEFAULT_COUNT_BITS = 22;

	localparam logic [LINE_BITS-1:0]  LINE_LIMIT_RESET  = 21'h100000;
	localparam logic [EVENT_BITS-1:0] EVENT_LIMIT_RESET = 22'h200000;

	// Configuration register indexes.
	localparam logic CFG_MAX_LINE  = 1'b0;
	localparam logic CFG_MAX_EVENT = 1'b1;

	// Stream bytes with a special meaning.
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Length of the "data:" prefix.
	localparam logic [2:0] PREFIX_LEN = 3'd5;

	typedef enum logic [1:0] {
		KIND_BYTE       = 2'd0,
		KIND_END        = 2'd1,
		KIND_LINE_FAIL  = 2'd2,
		KIND_EVENT_FAIL = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CLASS_UNDECIDED = 2'd0,
		CLASS_DATA      = 2'd1,
		CLASS_IGNORED   = 2'd2
	} line_class_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} result_t;

	// Character of "data:" at a given position of the line.
	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h64;
			3'd1: c = 8'h61;
			3'd2: c = 8'h74;
			3'd3: c = 8'h61;
			3'd4: c = 8'h3a;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/sdep_parse.sv */
// Line and event state of the parser and the per-byte decision logic.
`default_nettype none

module sdep_parse #(
	parameter int COUNT_BITS = sdep_pkg::DEFAULT_COUNT_BITS
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             fire,
	input  wire                             command,
	input  wire  [7:0]                      in_byte,
	input  wire  [sdep_pkg::LINE_BITS-1:0]  max_line,
	input  wire  [sdep_pkg::EVENT_BITS-1:0] max_event,
	output logic                            res_valid,
	output sdep_pkg::result_t               res
);
	import sdep_pkg::*;

	localparam int CMP_BITS = (COUNT_BITS > EVENT_BITS) ? COUNT_BITS : EVENT_BITS;

	logic                  failed_q, failed_d;
	logic [LINE_BITS-1:0]  line_len_q, line_len_d;
	logic [2:0]            pos_q, pos_d;
	line_class_t           class_q, class_d;
	logic                  space_q, space_d;
	logic [COUNT_BITS-1:0] ev_len_q, ev_len_d;
	logic                  over_q, over_d;

	logic                  ev_full;

	// The event count stops at the limit or at the top of the counter.
	always_comb begin
		ev_full = (CMP_BITS'(ev_len_q) >= CMP_BITS'(max_event)) || (&ev_len_q);
	end

	// Next state and result for the request in the input register.
	always_comb begin
		failed_d   = failed_q;
		line_len_d = line_len_q;
		pos_d      = pos_q;
		class_d    = class_q;
		space_d    = space_q;
		ev_len_d   = ev_len_q;
		over_d     = over_q;
		res_valid  = 1'b0;
		res.kind   = KIND_BYTE;
		res.data   = 8'h00;

		if (!failed_q) begin
			if (command || in_byte == CHAR_LF) begin
				if (line_len_q != '0 && class_q == CLASS_DATA && over_q) begin
					failed_d  = 1'b1;
					res_valid = 1'b1;
					res.kind  = KIND_EVENT_FAIL;
					ev_len_d  = '0;
					over_d    = 1'b0;
				end else if (command || line_len_q == '0) begin
					// Finish or empty line closes a non-empty event.
					if (ev_len_q != '0) begin
						res_valid = 1'b1;
						res.kind  = KIND_END;
					end
					ev_len_d = '0;
					over_d   = 1'b0;
				end
				line_len_d = '0;
				pos_d      = '0;
				class_d    = CLASS_UNDECIDED;
				space_d    = 1'b0;
			end else if (in_byte == CHAR_CR) begin
				// Carriage returns are dropped.
			end else if (line_len_q >= max_line) begin
				failed_d   = 1'b1;
				res_valid  = 1'b1;
				res.kind   = KIND_LINE_FAIL;
				line_len_d = '0;
				pos_d      = '0;
				class_d    = CLASS_UNDECIDED;
				space_d    = 1'b0;
				ev_len_d   = '0;
				over_d     = 1'b0;
			end else begin
				line_len_d = line_len_q + 1'b1;
				case (class_q)
					CLASS_UNDECIDED: begin
						if (pos_q < PREFIX_LEN && in_byte == prefix_char(pos_q)) begin
							pos_d = pos_q + 1'b1;
							if (pos_q == PREFIX_LEN - 1'b1) begin
								class_d = CLASS_DATA;
								space_d = 1'b1;
								// Separator before a further data line.
								if (ev_len_q != '0) begin
									if (ev_full) over_d = 1'b1;
									else ev_len_d = ev_len_q + 1'b1;
									res_valid = 1'b1;
									res.data  = CHAR_LF;
								end
							end
						end else begin
							class_d = CLASS_IGNORED;
						end
					end
					CLASS_DATA: begin
						space_d = 1'b0;
						if (!(space_q && in_byte == CHAR_SPACE)) begin
							if (ev_full) over_d = 1'b1;
							else ev_len_d = ev_len_q + 1'b1;
							res_valid = 1'b1;
							res.data  = in_byte;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// State registers advance once per processed request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q   <= 1'b0;
			line_len_q <= '0;
			pos_q      <= '0;
			class_q    <= CLASS_UNDECIDED;
			space_q    <= 1'b0;
			ev_len_q   <= '0;
			over_q     <= 1'b0;
		end else if (fire) begin
			failed_q   <= failed_d;
			line_len_q <= line_len_d;
			pos_q      <= pos_d;
			class_q    <= class_d;
			space_q    <= space_d;
			ev_len_q   <= ev_len_d;
			over_q     <= over_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/sdep_out_reg.sv */
// Result register that holds one result until the consumer takes it.
`default_nettype none

module sdep_out_reg (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               load,
	input  wire sdep_pkg::result_t res,
	input  wire               out_stall,
	output logic              out_valid,
	output logic              free,
	output logic [1:0]        kind,
	output logic [7:0]        out_byte
);
	import sdep_pkg::*;

	logic    valid_q;
	result_t res_q;

	// Room for a new result when empty or when the held one leaves now.
	always_comb begin
		free      = !valid_q || !out_stall;
		out_valid = valid_q;
		kind      = res_q.kind;
		out_byte  = res_q.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

/* rtl/sse_data_event_parser_unit.sv */
// Top level of the SSE data event parser: input register, parser, result register.
//
//  Channel  Signals                         Direction  Request holds
//  in       in_valid, in_stall              in         command, in_byte
//  out      out_valid, out_stall            out        kind, out_byte
//  cfg      cfg_we, cfg_index, cfg_data     in         register write
//
// One request per cycle is accepted while in_stall is low; it is held in the input
// register and its result, if any, is loaded into the result register once that has room.
// Reset clears all line and event state and loads the default limits.
// A stalled result holds the result register; the input register then
// holds its request and in_stall rises until the result register frees.
`default_nettype none

module sse_data_event_parser_unit #(
	parameter int COUNT_BITS = sdep_pkg::DEFAULT_COUNT_BITS
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire                             command,
	input  wire  [7:0]                      in_byte,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic [1:0]                      kind,
	output logic [7:0]                      out_byte,
	input  wire                             cfg_we,
	input  wire                             cfg_index,
	input  wire  [sdep_pkg::EVENT_BITS-1:0] cfg_data
);
	import sdep_pkg::*;

	logic                  valid_s1;
	logic                  command_s1;
	logic [7:0]            byte_s1;
	logic [LINE_BITS-1:0]  max_line_q;
	logic [EVENT_BITS-1:0] max_event_q;
	logic                  fire;
	logic                  free;
	logic                  res_valid;
	result_t               res;

	// The held request is processed when the result register has room.
	always_comb begin
		fire     = valid_s1 && free;
		in_stall = valid_s1 && !fire;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1 <= command;
			byte_s1    <= in_byte;
		end
	end

	// Limit registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_line_q  <= LINE_LIMIT_RESET;
			max_event_q <= EVENT_LIMIT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MAX_LINE) max_line_q <= cfg_data[LINE_BITS-1:0];
			if (cfg_index == CFG_MAX_EVENT) max_event_q <= cfg_data;
		end
	end

	sdep_parse #(
		.COUNT_BITS(COUNT_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.command   (command_s1),
		.in_byte   (byte_s1),
		.max_line  (max_line_q),
		.max_event (max_event_q),
		.res_valid (res_valid),
		.res       (res)
	);

	sdep_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.free      (free),
		.kind      (kind),
		.out_byte  (out_byte)
	);

endmodule

`default_nettype wire
